// ===== hdl/oaht_pkg.sv =====
// Shared types and constants for the open-addressing hash table.
// No dependencies; imported by oaht_probe and open_addressing_hash_table.
package oaht_pkg;

    // Table size must be a power of two (the slot index wraps by truncation).
    localparam int TABLE_SIZE   = 512;
    localparam int SLOT_BITS    = $clog2(TABLE_SIZE);
    localparam int KEY_BITS     = 31;
    localparam int PAYLOAD_BITS = 64;

    localparam logic [SLOT_BITS-1:0] SLOT_LAST        = SLOT_BITS'(TABLE_SIZE - 1);
    // offset(i+1) - offset(i) = 6i + 5 for offset(i) = 2i + 3i^2
    localparam logic [SLOT_BITS-1:0] PROBE_FIRST_STEP = SLOT_BITS'(5);
    localparam logic [SLOT_BITS-1:0] PROBE_STEP_INC   = SLOT_BITS'(6);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_UPDATE = 2'd1,
        OP_SELECT = 2'd2,
        OP_DELETE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_DUP  = 2'd1,
        ST_MISS = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    localparam logic [1:0] TAG_EMPTY   = 2'd0;
    localparam logic [1:0] TAG_USED    = 2'd1;
    localparam logic [1:0] TAG_DELETED = 2'd2;

    typedef struct packed {
        logic [1:0]              tag;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_entry;

    typedef struct packed {
        logic start;
        logic step;
    } t_probe_ctl;

endpackage

// ===== hdl/oaht_probe.sv =====
// Quadratic probe sequence generator: slot = home + 2i + 3i^2 mod TABLE_SIZE.
// Kept incrementally with a running step; depends on oaht_pkg.
module oaht_probe
    import oaht_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_probe_ctl           i_ctl,
    input  logic [SLOT_BITS-1:0] i_home,
    output logic [SLOT_BITS-1:0] o_slot,
    output logic                 o_last
);

    logic [SLOT_BITS-1:0] r_slot;
    logic [SLOT_BITS-1:0] r_delta;
    logic [SLOT_BITS-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_delta <= PROBE_FIRST_STEP;
            r_count <= '0;
        end else if (i_ctl.start) begin
            r_slot  <= i_home;
            r_delta <= PROBE_FIRST_STEP;
            r_count <= '0;
        end else if (i_ctl.step) begin
            r_slot  <= r_slot + r_delta;
            r_delta <= r_delta + PROBE_STEP_INC;
            r_count <= r_count + 1'b1;
        end
    end

    assign o_slot = r_slot;
    assign o_last = (r_count == SLOT_LAST);

endmodule

// ===== hdl/open_addressing_hash_table.sv =====
// Open-addressing hash table with quadratic probing over one slot memory.
// Depends on oaht_pkg and oaht_probe.
//
//   channel   valid         stall         fields
//   request   i_in_valid    o_in_stall    i_operation, i_key, i_payload
//   result    o_out_valid   i_out_stall   o_status, o_found_payload, o_slot_index
//
// A request visits p = 1 to TABLE_SIZE probes; each probe is a read of the single-port
// slot memory in S_READ followed by a compare in S_CHECK.
// After reset a clearing pass writes every slot empty, with o_in_stall high.
// A finished result waits in the output register; a new request is taken meanwhile,
// and the next result holds its last probe until that register is free.
module open_addressing_hash_table
    import oaht_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_operation,
    input  logic [KEY_BITS-1:0]     i_key,
    input  logic [PAYLOAD_BITS-1:0] i_payload,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [1:0]              o_status,
    output logic [PAYLOAD_BITS-1:0] o_found_payload,
    output logic [SLOT_BITS-1:0]    o_slot_index
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK
    } t_state;

    t_state                  r_state,     n_state;
    t_op                     r_op,        n_op;
    logic [KEY_BITS-1:0]     r_key,       n_key;
    logic [PAYLOAD_BITS-1:0] r_payload,   n_payload;
    logic [SLOT_BITS-1:0]    r_clr_addr,  n_clr_addr;
    logic                    r_out_valid, n_out_valid;
    t_status                 r_status,    n_status;
    logic [PAYLOAD_BITS-1:0] r_found,     n_found;
    logic [SLOT_BITS-1:0]    r_where,     n_where;

    t_entry                  mem [TABLE_SIZE];
    t_entry                  r_rdata;
    logic                    rd_en;
    logic                    wr_en;
    logic [SLOT_BITS-1:0]    wr_addr;
    t_entry                  wr_data;

    t_probe_ctl              probe_ctl;
    logic [SLOT_BITS-1:0]    probe_slot;
    logic                    probe_last;

    logic                    out_free;
    logic                    hit;
    logic                    finish;
    t_status                 fin_status;
    logic                    fin_write;
    logic                    fin_found;

    oaht_probe u_probe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (probe_ctl),
        .i_home  (i_key[SLOT_BITS-1:0]),
        .o_slot  (probe_slot),
        .o_last  (probe_last)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[probe_slot];
        end
    end

    assign rd_en    = (r_state == S_READ);
    assign out_free = !r_out_valid || !i_out_stall;
    assign hit      = (r_rdata.tag == TAG_USED) && (r_rdata.key == r_key);

    // probe outcome
    always_comb begin
        finish     = 1'b0;
        fin_status = ST_DONE;
        fin_write  = 1'b0;
        fin_found  = 1'b0;
        if (r_op == OP_INSERT) begin
            if (hit) begin
                finish     = 1'b1;
                fin_status = ST_DUP;
            end else if (r_rdata.tag != TAG_USED) begin
                finish     = 1'b1;
                fin_write  = 1'b1;
            end else if (probe_last) begin
                finish     = 1'b1;
                fin_status = ST_FULL;
            end
        end else begin
            if (r_rdata.tag == TAG_EMPTY) begin
                finish     = 1'b1;
                fin_status = ST_MISS;
            end else if (hit) begin
                finish     = 1'b1;
                fin_write  = (r_op != OP_SELECT);
                fin_found  = (r_op != OP_UPDATE);
            end else if (probe_last) begin
                finish     = 1'b1;
                fin_status = ST_MISS;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_payload   = r_payload;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_found     = r_found;
        n_where     = r_where;
        probe_ctl   = '0;
        wr_en       = 1'b0;
        wr_addr     = probe_slot;
        wr_data     = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                wr_en       = 1'b1;
                wr_addr     = r_clr_addr;
                wr_data.tag = TAG_EMPTY;
                n_clr_addr  = r_clr_addr + 1'b1;
                if (r_clr_addr == SLOT_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op            = t_op'(i_operation);
                    n_key           = i_key;
                    n_payload       = i_payload;
                    probe_ctl.start = 1'b1;
                    n_state         = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!finish) begin
                    probe_ctl.step = 1'b1;
                    n_state        = S_READ;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = fin_status;
                    n_found     = fin_found ? r_rdata.payload : '0;
                    n_where     = (fin_status == ST_DONE) ? probe_slot : '0;
                    if (fin_write) begin
                        wr_en           = 1'b1;
                        wr_data.key     = r_key;
                        wr_data.payload = r_payload;
                        wr_data.tag     = TAG_USED;
                        if (r_op == OP_DELETE) begin
                            wr_data.tag     = TAG_DELETED;
                            wr_data.payload = r_rdata.payload;
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
        r_op      <= n_op;
        r_key     <= n_key;
        r_payload <= n_payload;
        r_status  <= n_status;
        r_found   <= n_found;
        r_where   <= n_where;
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_found_payload = r_found;
    assign o_slot_index    = r_where;

`ifndef SYNTH
    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_CLEAR) || (r_state == S_CHECK && finish))
        else $error("slot memory written outside clear or final probe");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_READ) && !o_in_stall == 1'b0)
        else $error("accepted request did not start a probe read");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_DONE) |-> (o_slot_index == '0 && o_found_payload == '0))
        else $error("failed request reports slot or payload");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("pending result dropped");
`endif

endmodule

// ===== bench/open_addressing_hash_table_tb.sv =====
// Self-checking bench for open_addressing_hash_table: directed and random table requests,
// a shadow table predicts every result. Depends on oaht_pkg and the RTL under hdl/.
module open_addressing_hash_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import oaht_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int POOL_SIZE   = 48;

    typedef struct {
        t_op                     op;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] data;
    } t_table_req;

    typedef struct {
        logic [1:0]              status;
        logic [PAYLOAD_BITS-1:0] found;
        logic [SLOT_BITS-1:0]    slot;
    } t_table_resp;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                    req_valid  = 1'b0;
    logic [1:0]              req_op     = '0;
    logic [KEY_BITS-1:0]     req_key    = '0;
    logic [PAYLOAD_BITS-1:0] req_data   = '0;
    logic                    resp_stall = 1'b0;

    logic                    o_in_stall;
    logic                    o_out_valid;
    logic [1:0]              o_status;
    logic [PAYLOAD_BITS-1:0] o_found_payload;
    logic [SLOT_BITS-1:0]    o_slot_index;

    open_addressing_hash_table DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (req_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (req_op),
        .i_key           (req_key),
        .i_payload       (req_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (resp_stall),
        .o_status        (o_status),
        .o_found_payload (o_found_payload),
        .o_slot_index    (o_slot_index)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic [1:0]              shadow_tag  [TABLE_SIZE];
    logic [KEY_BITS-1:0]     shadow_key  [TABLE_SIZE];
    logic [PAYLOAD_BITS-1:0] shadow_data [TABLE_SIZE];

    t_table_req  request_q[$];
    t_table_resp outcome_q[$];

    function automatic logic [SLOT_BITS-1:0] probe_at(logic [KEY_BITS-1:0] key, int i);
        longint off;
        off = (2 * longint'(i) + 3 * longint'(i) * i) % TABLE_SIZE;
        return SLOT_BITS'((longint'(key) % TABLE_SIZE + off) % TABLE_SIZE);
    endfunction

    function automatic logic [KEY_BITS-1:0] homed_key(int home, longint hi);
        return KEY_BITS'(hi * TABLE_SIZE + home);
    endfunction

    // Walks the probe sequence of one request over the shadow table and updates it.
    function automatic t_table_resp table_access(t_table_req rq);
        t_table_resp          r;
        logic [SLOT_BITS-1:0] s;
        r.status = (rq.op == OP_INSERT) ? ST_FULL : ST_MISS;
        r.found  = '0;
        r.slot   = '0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            s = probe_at(rq.key, i);
            if (rq.op == OP_INSERT) begin
                if (shadow_tag[s] == TAG_USED) begin
                    if (shadow_key[s] == rq.key) begin
                        r.status = ST_DUP;
                        break;
                    end
                end else begin
                    shadow_tag[s]  = TAG_USED;
                    shadow_key[s]  = rq.key;
                    shadow_data[s] = rq.data;
                    r.status       = ST_DONE;
                    r.slot         = s;
                    break;
                end
            end else begin
                if (shadow_tag[s] == TAG_EMPTY)
                    break;
                if (shadow_tag[s] == TAG_USED && shadow_key[s] == rq.key) begin
                    r.status = ST_DONE;
                    r.slot   = s;
                    if (rq.op == OP_UPDATE) begin
                        shadow_data[s] = rq.data;
                    end else begin
                        r.found = shadow_data[s];
                        if (rq.op == OP_DELETE)
                            shadow_tag[s] = TAG_DELETED;
                    end
                    break;
                end
            end
        end
        return r;
    endfunction

    task automatic add_req(t_op op, logic [KEY_BITS-1:0] key, logic [PAYLOAD_BITS-1:0] data);
        t_table_req rq;
        rq.op   = op;
        rq.key  = key;
        rq.data = data;
        request_q.insert(request_q.size(), rq);
    endtask

    logic [KEY_BITS-1:0] key_pool [POOL_SIZE];

    task automatic add_random(int count);
        int                  pick;
        t_op                 op;
        logic [KEY_BITS-1:0] key;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                op = OP_INSERT;
            else if (pick < 55)
                op = OP_UPDATE;
            else if (pick < 80)
                op = OP_SELECT;
            else
                op = OP_DELETE;
            if ($urandom_range(0, 6) == 0)
                key = KEY_BITS'($urandom);
            else
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            add_req(op, key, PAYLOAD_BITS'({$urandom, $urandom}));
        end
    endtask

    // request side
    t_table_req cur_req;
    logic       req_fire   = 1'b0;
    int         gap_left   = 0;
    int         next_gap   = 0;
    int         sent       = 0;
    bit         send_quiet = 1'b0;

    always @(posedge i_clk) begin
        if (i_rst_n && req_valid && !o_in_stall)
            outcome_q.insert(outcome_q.size(), table_access(cur_req));
        req_fire <= i_rst_n && req_valid && !o_in_stall;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (req_fire)
                gap_left = next_gap;
            if (!req_valid || req_fire) begin
                if (gap_left > 0) begin
                    req_valid <= 1'b0;
                    gap_left--;
                end else if (request_q.size() > 0) begin
                    cur_req = request_q.pop_front();
                    req_op    <= cur_req.op;
                    req_key   <= cur_req.key;
                    req_data  <= cur_req.data;
                    req_valid <= 1'b1;
                    if (sent % 40 == 0)
                        send_quiet = ($urandom_range(0, 2) == 0);
                    sent++;
                    next_gap = send_quiet ? 0 : $urandom_range(0, 16);
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    logic resp_fire  = 1'b0;
    int   hold_left  = 0;
    int   stall_left = 0;
    int   got        = 0;
    bit   recv_quiet = 1'b0;
    int   errors     = 0;

    always @(posedge i_clk) begin
        t_table_resp want;
        if (i_rst_n && o_out_valid && !resp_stall) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: unexpected result: status %0d payload %h slot %0d",
                         $time, o_status, o_found_payload, o_slot_index);
                errors++;
            end else begin
                want = outcome_q.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, o_status);
                    errors++;
                end
                if (o_found_payload !== want.found) begin
                    $display("%0t: payload mismatch: expected %h, got %h",
                             $time, want.found, o_found_payload);
                    errors++;
                end
                if (o_slot_index !== want.slot) begin
                    $display("%0t: slot mismatch: expected %0d, got %0d",
                             $time, want.slot, o_slot_index);
                    errors++;
                end
            end
        end
        resp_fire <= i_rst_n && o_out_valid && !resp_stall;
    end

    always @(negedge i_clk) begin
        if (resp_fire) begin
            got++;
            if (got % 40 == 0)
                recv_quiet = ($urandom_range(0, 2) == 0);
            stall_left = recv_quiet ? 0 : $urandom_range(0, 16);
            // long hold-off so the request side backs up
            if (got == 150)
                hold_left = 600;
        end
        if (hold_left > 0) begin
            resp_stall <= 1'b1;
            hold_left--;
        end else if (stall_left > 0) begin
            resp_stall <= 1'b1;
            stall_left--;
        end else begin
            resp_stall <= 1'b0;
        end
    end

    int cycles = 0;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("open_addressing_hash_table regression: fail");
            $finish;
        end
    end

    initial begin
        logic [KEY_BITS-1:0]     key_max;
        logic [PAYLOAD_BITS-1:0] ones;
        int                      homes [6];
        bit                      seen [TABLE_SIZE];
        int                      chain_home;
        longint                  chain_base;
        int                      chain_len;
        int                      tail;

        foreach (shadow_tag[j])
            shadow_tag[j] = TAG_EMPTY;
        key_max = '1;
        ones    = '1;

        // directed: hits, duplicates, misses, reuse of deleted slots, key extremes
        add_req(OP_INSERT, '0, ones);
        add_req(OP_INSERT, '0, '0);
        add_req(OP_SELECT, '0, '0);
        add_req(OP_UPDATE, '0, '0);
        add_req(OP_SELECT, '0, ones);
        add_req(OP_DELETE, '0, ones);
        add_req(OP_SELECT, '0, '0);
        add_req(OP_DELETE, '0, '0);
        add_req(OP_UPDATE, '0, ones);
        add_req(OP_INSERT, homed_key(0, 1), {(PAYLOAD_BITS/2){2'b01}});
        add_req(OP_INSERT, homed_key(0, 2), {(PAYLOAD_BITS/2){2'b10}});
        add_req(OP_INSERT, key_max, ones);
        add_req(OP_SELECT, key_max, '0);
        add_req(OP_DELETE, homed_key(0, 1), '0);
        add_req(OP_SELECT, homed_key(0, 2), '0);
        add_req(OP_INSERT, homed_key(0, 2), PAYLOAD_BITS'(64'h0123_4567_89ab_cdef));
        add_req(OP_SELECT, homed_key(0, 2), '0);
        add_req(OP_DELETE, homed_key(0, 2), '0);
        add_req(OP_SELECT, homed_key(0, 2), '0);
        add_req(OP_UPDATE, homed_key(0, 2), ones);
        add_req(OP_DELETE, key_max, '0);
        add_req(OP_SELECT, homed_key(0, 3), '0);
        add_req(OP_INSERT, key_max, '0);

        // pool of keys sharing a few home slots
        homes[0] = 0;
        homes[1] = TABLE_SIZE - 1;
        for (int j = 2; j < 6; j++)
            homes[j] = $urandom_range(0, TABLE_SIZE - 1);
        for (int j = 0; j < POOL_SIZE; j++)
            key_pool[j] = homed_key(homes[j % 6],
                                    $urandom_range(0, (1 << (KEY_BITS - SLOT_BITS)) - 1));
        add_random(200);

        // fill one probe chain completely, then exhaust it
        chain_home = $urandom_range(0, TABLE_SIZE - 1);
        chain_base = $urandom_range(1, 1 << 20);
        chain_len  = 0;
        foreach (seen[j])
            seen[j] = 1'b0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (!seen[probe_at(KEY_BITS'(chain_home), i)]) begin
                seen[probe_at(KEY_BITS'(chain_home), i)] = 1'b1;
                chain_len++;
            end
        end
        for (int k = 0; k < chain_len + 6; k++)
            add_req(OP_INSERT, homed_key(chain_home, chain_base + k),
                    PAYLOAD_BITS'({$urandom, $urandom}));
        for (int k = 0; k < 4; k++)
            add_req(OP_SELECT, homed_key(chain_home, chain_base + chain_len + 100 + k), '0);
        add_req(OP_UPDATE, homed_key(chain_home, chain_base + chain_len + 110), ones);
        add_req(OP_DELETE, homed_key(chain_home, chain_base + chain_len + 111), '0);
        for (int k = 0; k < 8; k++)
            add_req(OP_SELECT, homed_key(chain_home, chain_base + $urandom_range(0, chain_len - 1)),
                    '0);
        for (int k = 0; k < 6; k++)
            add_req(OP_DELETE, homed_key(chain_home, chain_base + $urandom_range(0, chain_len - 1)),
                    '0);
        for (int k = 0; k < 6; k++)
            add_req(OP_INSERT, homed_key(chain_home, chain_base + chain_len + 200 + k),
                    PAYLOAD_BITS'({$urandom, $urandom}));

        tail = 600 - request_q.size();
        add_random((tail < 100) ? 100 : tail);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() != 0 || req_valid || outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (2 * TABLE_SIZE + 64) @(posedge i_clk);
        @(negedge i_clk);
        if (errors == 0 && outcome_q.size() == 0) begin
            $display("open_addressing_hash_table regression: pass");
        end else begin
            $display("open_addressing_hash_table regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/oaht_pkg.sv
hdl/oaht_probe.sv
hdl/open_addressing_hash_table.sv
bench/open_addressing_hash_table_tb.sv
